// File: sv/nv12rot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// NV12 rotation address generator package
// Shared widths, limits, register indexes and rotation codes.
// ----------------------------------------------------------------------------
package nv12rot_pkg;

    // Field and register widths.
    localparam int DIM_W    = 13;
    localparam int STRIDE_W = 15;
    localparam int COORD_W  = 12;
    localparam int SOFF_W   = 25;
    localparam int DOFF_W   = 27;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Saturation limits for the size registers.
    localparam logic [DIM_W-1:0]    MAX_DIM    = 13'd4096;
    localparam logic [STRIDE_W-1:0] MAX_STRIDE = 15'd16384;

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0]    RST_SRC_WIDTH  = 13'd1920;
    localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT = 13'd1080;
    localparam logic [STRIDE_W-1:0] RST_DST_STRIDE = 15'd1920;

    // Register indexes (word address).
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_STRIDE = 2'd2,
        REG_ROTATION   = 2'd3
    } reg_idx_t;

    // Counter-clockwise rotation codes.
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

endpackage
`default_nettype wire

// File: sv/nv12_rotation_address_generator.sv
`default_nettype none
// A transaction accepted with start passes the input, multiply and result
// register stages before its result shows with done high.
// Throughput: one coordinate per clock; busy is low at all times after reset.
// The result stage is never stalled, since the receiver cannot hold results off.
// Reset: rst_n clears the pipeline valids and restores the register defaults;
// busy is held high by reset and is cleared by the clock once reset is released.
// ----------------------------------------------------------------------------
// NV12 rotation address generator
// Maps a destination luma pixel or chroma pair to its packed source byte offset
// and its strided destination byte offset, for rotation by 0, 90, 180 or 270.
// ----------------------------------------------------------------------------
module nv12_rotation_address_generator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [nv12rot_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [nv12rot_pkg::DATA_W-1:0]     pwdata,
    output logic      [nv12rot_pkg::DATA_W-1:0]     prdata,
    output logic                                    pready,
    // Command side
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               plane,
    input  wire logic [nv12rot_pkg::COORD_W-1:0]    dst_col,
    input  wire logic [nv12rot_pkg::COORD_W-1:0]    dst_row,
    // Result side
    output logic                                    done,
    output logic      [nv12rot_pkg::SOFF_W-1:0]     src_offset,
    output logic      [nv12rot_pkg::DOFF_W-1:0]     dst_offset,
    output logic                                    in_range
);
    import nv12rot_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]    src_width_reg;
    logic [DIM_W-1:0]    src_height_reg;
    logic [STRIDE_W-1:0] dst_stride_reg;
    rot_t                rotation_reg;

    // Values derived from the configuration.
    logic [DIM_W-1:0]    sw_reg, sh_reg, ow_reg, oh_reg;
    logic [STRIDE_W-1:0] ds_reg;
    logic [SOFF_W-1:0]   base_s_reg;
    logic [DOFF_W-1:0]   base_d_reg;
    logic [DIM_W-1:0]    sw_next, sh_next;
    logic [STRIDE_W-1:0] ds_next;
    logic                swap_next;
    logic [2*DIM_W-1:0]  base_s_next;
    logic [STRIDE_W+DIM_W-1:0] base_d_next;

    // Input stage.
    logic                busy_reg;
    logic                v0_reg;
    logic                plane0_reg;
    logic [COORD_W-1:0]  col0_reg, row0_reg;
    logic                accept;

    // Multiply stage.
    logic                v1_reg, chroma1_reg, rng1_reg;
    logic [SOFF_W-1:0]   prod_s_reg;
    logic [DOFF_W-1:0]   prod_d_reg;
    logic [DIM_W-1:0]    sxe_reg, dce_reg;
    logic [DIM_W-1:0]    pw, ph, lw, lh, sx, sy;
    logic                rng_next;
    logic [SOFF_W-1:0]   prod_s_next;
    logic [DOFF_W-1:0]   prod_d_next;
    logic [DIM_W-1:0]    sxe_next, dce_next;

    // Result stage.
    logic                done_reg, in_range_reg;
    logic [SOFF_W-1:0]   src_offset_reg, src_offset_next;
    logic [DOFF_W-1:0]   dst_offset_reg, dst_offset_next;

    logic                cfg_wr;

    // APB write strobe; the port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            dst_stride_reg <= RST_DST_STRIDE;
            rotation_reg   <= ROT_0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[DIM_W-1:0];
                REG_DST_STRIDE: dst_stride_reg <= pwdata[STRIDE_W-1:0];
                REG_ROTATION:   rotation_reg   <= rot_t'(pwdata[1:0]);
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_SRC_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, src_width_reg};
            REG_SRC_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, src_height_reg};
            REG_DST_STRIDE: prdata = {{(DATA_W-STRIDE_W){1'b0}}, dst_stride_reg};
            REG_ROTATION:   prdata = {{(DATA_W-2){1'b0}}, rotation_reg};
            default:        prdata = '0;
        endcase
    end

    // Saturated sizes, output sizes and chroma plane bases.
    always_comb
    begin
        sw_next     = (src_width_reg > MAX_DIM) ? MAX_DIM : src_width_reg;
        sh_next     = (src_height_reg > MAX_DIM) ? MAX_DIM : src_height_reg;
        ds_next     = (dst_stride_reg > MAX_STRIDE) ? MAX_STRIDE : dst_stride_reg;
        swap_next   = rotation_reg inside {ROT_90, ROT_270};
        base_s_next = {{DIM_W{1'b0}}, sw_next} * {{DIM_W{1'b0}}, sh_next};
        base_d_next = {{DIM_W{1'b0}}, ds_next}
                    * {{STRIDE_W{1'b0}}, (swap_next ? sw_next : sh_next)};
    end

    always_ff @(posedge clk)
    begin
        sw_reg     <= sw_next;
        sh_reg     <= sh_next;
        ds_reg     <= ds_next;
        ow_reg     <= swap_next ? sh_next : sw_next;
        oh_reg     <= swap_next ? sw_next : sh_next;
        base_s_reg <= base_s_next[SOFF_W-1:0];
        base_d_reg <= base_d_next[DOFF_W-1:0];
    end

    // Input stage: capture one coordinate per cycle while busy is low.
    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v0_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v0_reg   <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plane0_reg <= plane;
            col0_reg   <= dst_col;
            row0_reg   <= dst_row;
        end
    end

    // Range check, source coordinate mapping and the row products.
    always_comb
    begin
        pw       = plane0_reg ? (sw_reg >> 1) : sw_reg;
        ph       = plane0_reg ? (sh_reg >> 1) : sh_reg;
        lw       = plane0_reg ? (ow_reg >> 1) : ow_reg;
        lh       = plane0_reg ? (oh_reg >> 1) : oh_reg;
        rng_next = ({1'b0, col0_reg} < lw) && ({1'b0, row0_reg} < lh);
        case (rotation_reg)
            ROT_90:
            begin
                sx = pw - {{(DIM_W-1){1'b0}}, 1'b1} - {1'b0, row0_reg};
                sy = {1'b0, col0_reg};
            end
            ROT_180:
            begin
                sx = pw - {{(DIM_W-1){1'b0}}, 1'b1} - {1'b0, col0_reg};
                sy = ph - {{(DIM_W-1){1'b0}}, 1'b1} - {1'b0, row0_reg};
            end
            ROT_270:
            begin
                sx = {1'b0, row0_reg};
                sy = ph - {{(DIM_W-1){1'b0}}, 1'b1} - {1'b0, col0_reg};
            end
            default:
            begin
                sx = {1'b0, col0_reg};
                sy = {1'b0, row0_reg};
            end
        endcase
        // In range, both source coordinates fit in COORD_W bits.
        prod_s_next = {{DIM_W{1'b0}}, sy[COORD_W-1:0]} * {{COORD_W{1'b0}}, sw_reg};
        prod_d_next = {{STRIDE_W{1'b0}}, row0_reg} * {{COORD_W{1'b0}}, ds_reg};
        sxe_next    = plane0_reg ? {sx[COORD_W-1:0], 1'b0} : {1'b0, sx[COORD_W-1:0]};
        dce_next    = plane0_reg ? {col0_reg, 1'b0} : {1'b0, col0_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        chroma1_reg <= plane0_reg;
        rng1_reg    <= rng_next;
        prod_s_reg  <= prod_s_next;
        prod_d_reg  <= prod_d_next;
        sxe_reg     <= sxe_next;
        dce_reg     <= dce_next;
    end

    // Final sums with the chroma plane base; out-of-range gives zero offsets.
    always_comb
    begin
        src_offset_next = prod_s_reg + {{(SOFF_W-DIM_W){1'b0}}, sxe_reg}
                        + (chroma1_reg ? base_s_reg : '0);
        dst_offset_next = prod_d_reg + {{(DOFF_W-DIM_W){1'b0}}, dce_reg}
                        + (chroma1_reg ? base_d_reg : '0);
        if (!rng1_reg)
        begin
            src_offset_next = '0;
            dst_offset_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            src_offset_reg <= src_offset_next;
            dst_offset_reg <= dst_offset_next;
            in_range_reg   <= rng1_reg;
        end
    end

    assign done       = done_reg;
    assign src_offset = src_offset_reg;
    assign dst_offset = dst_offset_reg;
    assign in_range   = in_range_reg;

    // Every accepted transaction raises done once it has passed the input,
    // multiply and result register stages.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("accepted transaction produced no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v1_reg, 1) && $past(start && !busy, 3))
        else $error("result without an accepted transaction");

    a_zero_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_range) |-> (src_offset == '0) && (dst_offset == '0))
        else $error("out-of-range result carries nonzero offsets");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised outside reset");

endmodule
`default_nettype wire
